// ----- hw/rtl/vec4_geometry_alu_macros.svh -----
`ifndef VEC4_GEOMETRY_ALU_MACROS_SVH
`define VEC4_GEOMETRY_ALU_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define V4G_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define V4G_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/v4g_pkg.sv -----
`default_nettype none

package v4g_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned NumTerms  = 4;
  localparam int unsigned NumStages = 5;
  localparam int unsigned NumMatReg = 8;
  localparam int unsigned FracBits  = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_XFORM = 3'd5,
    OP_QUAT  = 3'd6,
    OP_SCALE = 3'd7
  } op_e;

  typedef logic signed [31:0] comp_t;
  typedef logic signed [32:0] opnd_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [66:0] pair_t;
  typedef logic signed [67:0] sum_t;

  // 1.0 in Q16.16, used to push add/sub through the multipliers unchanged
  localparam opnd_t OneQ = opnd_t'(33'sd65536);

  function automatic opnd_t sx(input comp_t v);
    return {v[31], v};
  endfunction

  function automatic opnd_t nsx(input comp_t v);
    opnd_t t;
    t = {v[31], v};
    return -t;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vec4_geometry_alu.sv -----
`default_nettype none
`include "vec4_geometry_alu_macros.svh"

// Q16.16 four-component vector ALU: add, sub, elementwise mul, dot4, cross3,
// 4x4 matrix transform, quaternion product and scale. One request is taken
// every clock cycle when the output side does not stall; results leave from
// the last of the five register stages, which are operand select, sixteen
// parallel 33x33 multipliers, pairwise sums, lane sums, and the 16-bit floor
// shift with 32-bit saturation. Every operation, add and sub included, runs
// through the same multiplier lanes. Backpressure stalls only the stages that
// hold data, so bubbles are squeezed out. The matrix sits in eight 64-bit
// registers on the APB-style port (entry 2k low, 2k+1 high, at 8*k) and
// resets to identity; write it only while the pipeline is empty.
module vec4_geometry_alu import v4g_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  wire logic [255:0] s_axis_tdata,
  // req_type
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // r_x, r_y, r_z, r_w
  output logic [127:0]      m_axis_tdata,
  // overflow
  output logic [0:0]        m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] mat_q [NumMatReg];
  comp_t       ment  [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= 64'h0000_0000_0001_0000;
      mat_q[1] <= '0;
      mat_q[2] <= 64'h0001_0000_0000_0000;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= 64'h0000_0000_0001_0000;
      mat_q[6] <= '0;
      mat_q[7] <= 64'h0001_0000_0000_0000;
    end else if (psel && penable && pwrite && pready) begin
      mat_q[paddr[5:3]] <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = mat_q[paddr[5:3]];

  always_comb begin
    for (int e = 0; e < 16; e++) begin
      ment[e] = e[0] ? mat_q[e >> 1][63:32] : mat_q[e >> 1][31:0];
    end
  end

  // stage handshake: a stage loads when it is empty or its successor moves
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] rdy;

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // operand select
  comp_t a [NumLanes];
  comp_t b [NumLanes];
  op_e   op;
  opnd_t opa_d [NumLanes][NumTerms];
  opnd_t opb_d [NumLanes][NumTerms];
  opnd_t opa_q [NumLanes][NumTerms];
  opnd_t opb_q [NumLanes][NumTerms];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      a[i] = s_axis_tdata[32*i +: 32];
      b[i] = s_axis_tdata[128 + 32*i +: 32];
    end
    op = op_e'(s_axis_tuser);
    for (int j = 0; j < NumLanes; j++) begin
      for (int k = 0; k < NumTerms; k++) begin
        opa_d[j][k] = '0;
        opb_d[j][k] = '0;
      end
    end
    unique case (op) inside
      OP_ADD, OP_SUB: begin
        for (int j = 0; j < NumLanes; j++) begin
          opa_d[j][0] = sx(a[j]);
          opb_d[j][0] = OneQ;
          opa_d[j][1] = (op == OP_SUB) ? nsx(b[j]) : sx(b[j]);
          opb_d[j][1] = OneQ;
        end
      end
      OP_MUL: begin
        for (int j = 0; j < NumLanes; j++) begin
          opa_d[j][0] = sx(a[j]);
          opb_d[j][0] = sx(b[j]);
        end
      end
      OP_DOT: begin
        for (int k = 0; k < NumTerms; k++) begin
          opa_d[0][k] = sx(a[k]);
          opb_d[0][k] = sx(b[k]);
        end
      end
      OP_CROSS: begin
        opa_d[0][0] = sx(a[1]);  opb_d[0][0] = sx(b[2]);
        opa_d[0][1] = nsx(a[2]); opb_d[0][1] = sx(b[1]);
        opa_d[1][0] = sx(a[2]);  opb_d[1][0] = sx(b[0]);
        opa_d[1][1] = nsx(a[0]); opb_d[1][1] = sx(b[2]);
        opa_d[2][0] = sx(a[0]);  opb_d[2][0] = sx(b[1]);
        opa_d[2][1] = nsx(a[1]); opb_d[2][1] = sx(b[0]);
      end
      OP_XFORM: begin
        for (int j = 0; j < NumLanes; j++) begin
          for (int k = 0; k < NumTerms; k++) begin
            opa_d[j][k] = sx(a[k]);
            opb_d[j][k] = sx(ment[4*k + j]);
          end
        end
      end
      OP_QUAT: begin
        // vector part: aw*bv + bw*av + av x bv
        opa_d[0][0] = sx(a[3]);  opb_d[0][0] = sx(b[0]);
        opa_d[0][1] = sx(b[3]);  opb_d[0][1] = sx(a[0]);
        opa_d[0][2] = sx(a[1]);  opb_d[0][2] = sx(b[2]);
        opa_d[0][3] = nsx(a[2]); opb_d[0][3] = sx(b[1]);
        opa_d[1][0] = sx(a[3]);  opb_d[1][0] = sx(b[1]);
        opa_d[1][1] = sx(b[3]);  opb_d[1][1] = sx(a[1]);
        opa_d[1][2] = sx(a[2]);  opb_d[1][2] = sx(b[0]);
        opa_d[1][3] = nsx(a[0]); opb_d[1][3] = sx(b[2]);
        opa_d[2][0] = sx(a[3]);  opb_d[2][0] = sx(b[2]);
        opa_d[2][1] = sx(b[3]);  opb_d[2][1] = sx(a[2]);
        opa_d[2][2] = sx(a[0]);  opb_d[2][2] = sx(b[1]);
        opa_d[2][3] = nsx(a[1]); opb_d[2][3] = sx(b[0]);
        // scalar part
        opa_d[3][0] = sx(a[3]);  opb_d[3][0] = sx(b[3]);
        opa_d[3][1] = nsx(a[0]); opb_d[3][1] = sx(b[0]);
        opa_d[3][2] = nsx(a[1]); opb_d[3][2] = sx(b[1]);
        opa_d[3][3] = nsx(a[2]); opb_d[3][3] = sx(b[2]);
      end
      OP_SCALE: begin
        for (int j = 0; j < NumLanes; j++) begin
          opa_d[j][0] = sx(a[j]);
          opb_d[j][0] = sx(b[0]);
        end
      end
    endcase
  end

  prod_t prod_q [NumLanes][NumTerms];
  pair_t pair_q [NumLanes][2];
  sum_t  sum_q  [NumLanes];
  comp_t r_d    [NumLanes];
  comp_t r_q    [NumLanes];
  logic  [NumLanes-1:0] sat;
  logic  ovf_q;

  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      logic [51:0] sh;
      sh = sum_q[j][67:FracBits];
      sat[j] = !((&sh[51:31]) || !(|sh[51:31]));
      if (!sat[j]) begin
        r_d[j] = sh[31:0];
      end else if (sh[51]) begin
        r_d[j] = 32'h8000_0000;
      end else begin
        r_d[j] = 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
    if (rdy[1] && v_q[0]) begin
      for (int j = 0; j < NumLanes; j++) begin
        for (int k = 0; k < NumTerms; k++) begin
          prod_q[j][k] <= opa_q[j][k] * opb_q[j][k];
        end
      end
    end
    if (rdy[2] && v_q[1]) begin
      for (int j = 0; j < NumLanes; j++) begin
        pair_q[j][0] <= pair_t'(prod_q[j][0]) + pair_t'(prod_q[j][1]);
        pair_q[j][1] <= pair_t'(prod_q[j][2]) + pair_t'(prod_q[j][3]);
      end
    end
    if (rdy[3] && v_q[2]) begin
      for (int j = 0; j < NumLanes; j++) begin
        sum_q[j] <= sum_t'(pair_q[j][0]) + sum_t'(pair_q[j][1]);
      end
    end
    if (rdy[4] && v_q[3]) begin
      r_q   <= r_d;
      ovf_q <= |sat;
    end
  end

  assign m_axis_tvalid   = v_q[NumStages-1];
  assign m_axis_tdata    = {r_q[3], r_q[2], r_q[1], r_q[0]};
  assign m_axis_tuser[0] = ovf_q;

  `V4G_ASSERT_IMP(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready,
                  "input stalled while output stage empty")
  `V4G_ASSERT_NXT(a_accept_lands, s_axis_tvalid && s_axis_tready, v_q[0],
                  "accepted request did not enter first stage")
  `V4G_ASSERT_NXT(a_last_stage_fills, v_q[3] && rdy[4], m_axis_tvalid,
                  "request lost before output stage")
  `V4G_ASSERT_IMP(a_ovf_has_sat, m_axis_tvalid && m_axis_tuser[0],
                  r_q[0] == 32'h7fff_ffff || r_q[0] == 32'h8000_0000 ||
                  r_q[1] == 32'h7fff_ffff || r_q[1] == 32'h8000_0000 ||
                  r_q[2] == 32'h7fff_ffff || r_q[2] == 32'h8000_0000 ||
                  r_q[3] == 32'h7fff_ffff || r_q[3] == 32'h8000_0000,
                  "overflow flagged without a saturated component")

endmodule

`default_nettype wire

// ----- sim/tb_vec4_geometry_alu.sv -----
`timescale 1ns / 100ps

module tb_vec4_geometry_alu import v4g_pkg::*; ();

  typedef struct {
    op_e   op;
    comp_t a [4];
    comp_t b [4];
  } vec_req_t;

  typedef struct {
    comp_t r [4];
    logic  ovf;
  } vec_res_t;

  localparam comp_t CompMax = 32'sh7FFF_FFFF;
  localparam comp_t CompMin = 32'sh8000_0000;
  localparam comp_t CompOne = 32'sh0001_0000;
  localparam sum_t  SatHi   = 68'sd2147483647;
  localparam sum_t  SatLo   = -68'sd2147483648;
  localparam int    RandPerPhase = 175;
  localparam int    NumPhases    = 6;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  // matrix as the block should hold it, starts at the identity
  logic [63:0] mat_pair [8] = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                                64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};

  vec_req_t pending_reqs [$];
  vec_res_t expected_results [$];
  vec_req_t cur_req;
  int       issued_cnt = 0;
  int       taken_cnt = 0;
  int       results_seen = 0;
  int       fail_cnt = 0;

  vec4_geometry_alu DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic sum_t wide_mul(comp_t x, comp_t y);
    return sum_t'(x) * sum_t'(y);
  endfunction

  function automatic comp_t mat_entry(int k);
    logic [63:0] pair;
    pair = mat_pair[k >> 1];
    return comp_t'(k[0] ? pair[63:32] : pair[31:0]);
  endfunction

  function automatic comp_t saturate(sum_t acc, logic do_shift, inout logic ovf);
    sum_t v;
    v = do_shift ? (acc >>> FracBits) : acc;
    if (v > SatHi) begin
      ovf = 1'b1;
      return CompMax;
    end else if (v < SatLo) begin
      ovf = 1'b1;
      return CompMin;
    end
    return comp_t'(v);
  endfunction

  function automatic vec_res_t vec_alu_result(vec_req_t rq);
    sum_t     acc [4];
    vec_res_t res;
    int       lanes;
    int       p;
    int       q;
    logic     do_shift;
    lanes = 4;
    do_shift = 1'b1;
    res.ovf = 1'b0;
    for (int i = 0; i < 4; i++) acc[i] = '0;
    case (rq.op) inside
      OP_ADD, OP_SUB: begin
        do_shift = 1'b0;
        for (int i = 0; i < 4; i++)
          acc[i] = (rq.op == OP_ADD) ? sum_t'(rq.a[i]) + sum_t'(rq.b[i])
                                     : sum_t'(rq.a[i]) - sum_t'(rq.b[i]);
      end
      OP_MUL: begin
        for (int i = 0; i < 4; i++) acc[i] = wide_mul(rq.a[i], rq.b[i]);
      end
      OP_DOT: begin
        lanes = 1;
        for (int i = 0; i < 4; i++) acc[0] += wide_mul(rq.a[i], rq.b[i]);
      end
      OP_CROSS: begin
        lanes = 3;
        for (int i = 0; i < 3; i++) begin
          p = (i + 1) % 3;
          q = (i + 2) % 3;
          acc[i] = wide_mul(rq.a[p], rq.b[q]) - wide_mul(rq.a[q], rq.b[p]);
        end
      end
      OP_XFORM: begin
        for (int j = 0; j < 4; j++)
          for (int i = 0; i < 4; i++) acc[j] += wide_mul(rq.a[i], mat_entry(4 * i + j));
      end
      OP_QUAT: begin
        acc[3] = wide_mul(rq.a[3], rq.b[3]);
        for (int i = 0; i < 3; i++) acc[3] -= wide_mul(rq.a[i], rq.b[i]);
        for (int i = 0; i < 3; i++) begin
          p = (i + 1) % 3;
          q = (i + 2) % 3;
          acc[i] = wide_mul(rq.a[3], rq.b[i]) + wide_mul(rq.b[3], rq.a[i])
                 + wide_mul(rq.a[p], rq.b[q]) - wide_mul(rq.a[q], rq.b[p]);
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) acc[i] = wide_mul(rq.a[i], rq.b[0]);
      end
    endcase
    for (int i = 0; i < 4; i++)
      res.r[i] = (i < lanes) ? saturate(acc[i], do_shift, res.ovf) : comp_t'(0);
    return res;
  endfunction

  // sender: one request offered at a time until taken, random gaps between requests
  int send_gap = 0;
  bit send_idle = 1'b1;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (issued_cnt != taken_cnt) begin
        // request still waiting for tready
      end else if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata <= {cur_req.b[3], cur_req.b[2], cur_req.b[1], cur_req.b[0],
                         cur_req.a[3], cur_req.a[2], cur_req.a[1], cur_req.a[0]};
        s_axis_tuser <= cur_req.op;
        s_axis_tvalid <= 1'b1;
        issued_cnt++;
        if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
        send_gap = send_idle ? $urandom_range(0, 4) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall drawn per result
  int  stall_cnt = 0;
  int  stall_ref = 0;
  bit  recv_idle = 1'b1;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_seen != stall_ref) begin
        stall_ref = results_seen;
        if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
        stall_cnt = recv_idle ? $urandom_range(0, 4) : 0;
      end
      if (stall_cnt != 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  string lane_name [4] = '{"r_x", "r_y", "r_z", "r_w"};

  always @(posedge clk_i) begin : monitor
    vec_res_t want;
    comp_t    got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(vec_alu_result(cur_req));
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 4; i++) begin
            got = comp_t'(m_axis_tdata[32*i +: 32]);
            if (got !== want.r[i]) begin
              $error("%s: expected %0d, got %0d", lane_name[i], want.r[i], got);
              fail_cnt++;
            end
          end
          if (m_axis_tuser[0] !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, m_axis_tuser[0]);
            fail_cnt++;
          end
        end
      end
    end
  end

  task automatic apb_xfer(input logic wr, input int k, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 6'(8 * k);
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_mat_pair(int k);
    logic [63:0] rd;
    apb_xfer(1'b0, k, 64'h0, rd);
    if (rd !== mat_pair[k]) begin
      $error("mat_pair_%0d readback: expected %h, got %h", k, mat_pair[k], rd);
      fail_cnt++;
    end
  endtask

  task automatic write_mat_pair(int k, logic [63:0] val);
    logic [63:0] rd;
    apb_xfer(1'b1, k, val, rd);
    mat_pair[k] = val;
    check_mat_pair(k);
  endtask

  task automatic queue_req(op_e op, comp_t a [4], comp_t b [4]);
    vec_req_t rq;
    rq.op = op;
    rq.a = a;
    rq.b = b;
    pending_reqs.push_back(rq);
  endtask

  function automatic comp_t pick_comp();
    case ($urandom_range(0, 5))
      0, 1, 2: return comp_t'($urandom);
      3, 4:    return comp_t'($urandom_range(0, 32'h0010_0000)) - comp_t'(32'h0008_0000);
      default: begin
        case ($urandom_range(0, 5))
          0:       return CompMax;
          1:       return CompMin;
          2:       return CompOne;
          3:       return -CompOne;
          4:       return comp_t'(-1);
          default: return comp_t'(0);
        endcase
      end
    endcase
  endfunction

  // wait until the pipe is empty, then let the stages settle
  task automatic drain();
    while (pending_reqs.size() != 0 || issued_cnt != taken_cnt || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    comp_t       va [4];
    comp_t       vb [4];
    comp_t       mix_a [4];
    comp_t       mix_b [4];
    comp_t       all_max [4];
    comp_t       all_min [4];
    logic [63:0] pair;
    op_e         op;
    mix_a = '{CompMax, CompMin, comp_t'(-1), CompOne};
    mix_b = '{CompMin, CompMax, CompOne, comp_t'(-1)};
    all_max = '{CompMax, CompMax, CompMax, CompMax};
    all_min = '{CompMin, CompMin, CompMin, CompMin};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < NumMatReg; k++) check_mat_pair(k);

    // every operation on the operand extremes, floor rounding of negatives in the mixed set
    op = op.first();
    do begin
      queue_req(op, all_max, all_max);
      queue_req(op, all_min, all_min);
      queue_req(op, mix_a, mix_b);
      op = op.next();
    end while (op != op.first());

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain();
        for (int k = 0; k < NumMatReg; k++) begin
          case (ph)
            1: pair = {$urandom, $urandom};
            2: pair = {32'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000),
                       32'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000)};
            3: pair = {CompMax, CompMax};
            4: pair = {CompMin, CompMin};
            default: pair = 64'h0;
          endcase
          write_mat_pair(k, pair);
        end
        // the last matrix is zero but entries 0 and 1 (max and min); each matrix gets the extreme operands
        if (ph == NumPhases - 1) write_mat_pair(0, {CompMin, CompMax});
        queue_req(OP_XFORM, all_max, all_max);
        queue_req(OP_XFORM, all_min, all_min);
        queue_req(OP_XFORM, mix_a, mix_b);
      end
      for (int n = 0; n < RandPerPhase; n++) begin
        for (int i = 0; i < 4; i++) begin
          va[i] = pick_comp();
          vb[i] = pick_comp();
        end
        queue_req(op_e'($urandom_range(OP_ADD, OP_SCALE)), va, vb);
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/v4g_pkg.sv
hw/rtl/vec4_geometry_alu.sv
sim/tb_vec4_geometry_alu.sv
